// File: hw/rtl/spi_port_demux_with_keyboard_responder_defines.svh
// assertion macros shared by the spi port demux rtl
// users provide clk and rst_n in scope
`ifndef SPI_PORT_DEMUX_WITH_KEYBOARD_RESPONDER_DEFINES_SVH
`define SPI_PORT_DEMUX_WITH_KEYBOARD_RESPONDER_DEFINES_SVH

// same-cycle implication
`define SPDK_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPDK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/spdk_pkg.sv
// shared types and codes for the spi port demux with keyboard responder
// no dependencies
package spdk_pkg;

    localparam logic [7:0] SD_INIT_CLOCKS_RST = 8'd74;
    localparam logic [7:0] BITS_PER_BYTE      = 8'd8;

    // keyboard replies
    localparam logic [7:0] KBD_ACK     = 8'hfa;
    localparam logic [7:0] KBD_ID_OK   = 8'haa;
    localparam logic [7:0] KBD_NONE    = 8'hff;

    // keyboard commands
    localparam logic [7:0] KBD_CMD_RESTART    = 8'hff;
    localparam logic [7:0] KBD_CMD_ENABLE     = 8'hf4;
    localparam logic [7:0] KBD_CMD_DISABLE    = 8'hf5;
    localparam logic [7:0] KBD_CMD_RATE       = 8'hf3;
    localparam logic [7:0] KBD_CMD_INDICATORS = 8'hed;
    localparam logic [7:0] KBD_CMD_STAT1      = 8'h01;
    localparam logic [7:0] KBD_CMD_STAT2      = 8'h02;

    typedef enum logic [1:0] {
        DEV_SD  = 2'd0,
        DEV_KBD = 2'd1,
        DEV_RTC = 2'd2
    } dev_t;

    typedef struct packed {
        logic       sd_select_pulse;
        logic       rtc_select_pulse;
        logic       rtc_deselect_pulse;
        logic       byte_done;
        logic [1:0] target_device;
        logic [7:0] received_byte;
        logic       reply_valid;
        logic [7:0] reply_byte;
        logic       kbd_irq_clear;
    } res_t;

endpackage

// File: hw/rtl/spdk_core.sv
// per-word decode: select edges, mosi shifter, sd holdoff, keyboard responder
// depends on spdk_pkg
module spdk_core
    import spdk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       accept,
    input  logic       action,
    input  logic [7:0] port,
    input  logic [7:0] keycode,
    output res_t       res
);

    logic       prev_sd_reg, prev_sd_next;
    logic       prev_kbd_reg, prev_kbd_next;
    logic       prev_rtc_reg, prev_rtc_next;
    logic       prev_clock_reg, prev_clock_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] bit_count_reg, bit_count_next;
    logic       sd_ready_reg, sd_ready_next;
    logic [7:0] init_count_reg, init_count_next;
    logic [7:0] pending_reg, pending_next;
    logic [7:0] key_latch_reg, key_latch_next;
    logic [7:0] sd_init_clocks_reg;

    logic       sd, kb, rtc, clk_bit, mosi;
    logic [7:0] bc_mid, bc_inc, init_inc;
    logic       rise;

    always_comb
    begin
        prev_sd_next    = prev_sd_reg;
        prev_kbd_next   = prev_kbd_reg;
        prev_rtc_next   = prev_rtc_reg;
        prev_clock_next = prev_clock_reg;
        shift_next      = shift_reg;
        bit_count_next  = bit_count_reg;
        sd_ready_next   = sd_ready_reg;
        init_count_next = init_count_reg;
        pending_next    = pending_reg;
        key_latch_next  = key_latch_reg;
        res             = '0;

        clk_bit  = port[0];
        sd       = ~port[1];
        kb       = ~port[2];
        rtc      = ~port[3];
        mosi     = port[7];
        bc_mid   = bit_count_reg;
        rise     = 1'b0;
        bc_inc   = 8'd0;
        init_inc = init_count_reg + 8'd1;

        if (action)
        begin
            key_latch_next = keycode;
        end
        else
        begin
            // only the first edge in priority order is acted on
            if (!prev_sd_reg && sd)
            begin
                bc_mid              = 8'd0;
                res.sd_select_pulse = 1'b1;
            end
            else if (!prev_kbd_reg && kb)
            begin
                bc_mid = 8'd0;
            end
            else if (!prev_rtc_reg && rtc)
            begin
                bc_mid               = 8'd0;
                res.rtc_select_pulse = 1'b1;
            end
            else if (prev_rtc_reg && !rtc)
            begin
                res.rtc_deselect_pulse = 1'b1;
            end
            prev_sd_next   = sd;
            prev_kbd_next  = kb;
            prev_rtc_next  = rtc;
            bit_count_next = bc_mid;

            // clock tracked only while some device is selected
            if ((sd || kb || rtc) && (clk_bit != prev_clock_reg))
            begin
                prev_clock_next = clk_bit;
                rise            = clk_bit;
            end

            bc_inc = bc_mid + 8'd1;
            if (rise)
            begin
                shift_next     = {shift_reg[6:0], mosi};
                bit_count_next = bc_inc;
                if (sd && !sd_ready_reg)
                begin
                    init_count_next = init_inc;
                    if (init_inc >= sd_init_clocks_reg)
                    begin
                        sd_ready_next       = 1'b1;
                        res.sd_select_pulse = 1'b1;
                    end
                end
                else if (bc_inc == BITS_PER_BYTE)
                begin
                    bit_count_next    = 8'd0;
                    res.byte_done     = 1'b1;
                    res.received_byte = shift_next;
                    if (sd)
                    begin
                        res.target_device = DEV_SD;
                    end
                    else if (kb)
                    begin
                        res.target_device = DEV_KBD;
                        res.reply_valid   = 1'b1;
                        if (shift_next != 8'd0 && pending_reg == 8'd0)
                        begin
                            case (shift_next)
                                KBD_CMD_RESTART, KBD_CMD_ENABLE, KBD_CMD_DISABLE,
                                KBD_CMD_RATE, KBD_CMD_INDICATORS:
                                begin
                                    pending_next   = shift_next;
                                    res.reply_byte = KBD_ACK;
                                end
                                KBD_CMD_STAT1, KBD_CMD_STAT2:
                                    res.reply_byte = KBD_ID_OK;
                                default:
                                    res.reply_byte = KBD_NONE;
                            endcase
                        end
                        else
                        begin
                            // rate command takes its argument, anything else reads the key
                            if (pending_reg == KBD_CMD_RATE)
                            begin
                                res.reply_byte = KBD_ACK;
                            end
                            else
                            begin
                                res.reply_byte    = key_latch_reg;
                                key_latch_next    = 8'd0;
                                res.kbd_irq_clear = 1'b1;
                            end
                            pending_next = 8'd0;
                        end
                    end
                    else
                    begin
                        res.target_device = DEV_RTC;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sd_reg        <= 1'b0;
            prev_kbd_reg       <= 1'b0;
            prev_rtc_reg       <= 1'b0;
            prev_clock_reg     <= 1'b0;
            shift_reg          <= 8'd0;
            bit_count_reg      <= 8'd0;
            sd_ready_reg       <= 1'b0;
            init_count_reg     <= 8'd0;
            pending_reg        <= 8'd0;
            key_latch_reg      <= 8'd0;
            sd_init_clocks_reg <= SD_INIT_CLOCKS_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                sd_init_clocks_reg <= cfg_wdata;
            end
            if (accept)
            begin
                prev_sd_reg    <= prev_sd_next;
                prev_kbd_reg   <= prev_kbd_next;
                prev_rtc_reg   <= prev_rtc_next;
                prev_clock_reg <= prev_clock_next;
                shift_reg      <= shift_next;
                bit_count_reg  <= bit_count_next;
                sd_ready_reg   <= sd_ready_next;
                init_count_reg <= init_count_next;
                pending_reg    <= pending_next;
                key_latch_reg  <= key_latch_next;
            end
        end
    end

endmodule

// File: hw/rtl/spdk_outbuf.sv
// two-entry result buffer: output register plus skid register
// depends on spdk_pkg and the shared assertion macros
`include "spi_port_demux_with_keyboard_responder_defines.svh"

module spdk_outbuf
    import spdk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output res_t out_data
);

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;
    logic pop;

    assign pop = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = push_data;
                skid_valid_next = push;
            end
            else
            begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            // output word held, park the new one
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SPDK_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid word without output word")
    `SPDK_ASSERT_NEXT(a_park_on_stall, out_valid_reg && out_stall && push, skid_valid_reg, "word lost on stall")
    `SPDK_ASSERT_NEXT(a_skid_moves_up, skid_valid_reg && !out_stall, out_valid_reg && out_reg == $past(skid_reg), "skid word not forwarded")
    `SPDK_ASSERT_NEXT(a_drain_empty, pop && !skid_valid_reg && !push, !out_valid_reg, "word repeated after drain")

endmodule

// File: hw/rtl/spi_port_demux_with_keyboard_responder.sv
// Top level of the spi port demux with keyboard responder.
// Depends on spdk_pkg, spdk_core and spdk_outbuf.
//
// Usage:
// - input channel (in_valid/in_stall) carries one word per item: action, port, keycode.
//   action 0 is a port sample, action 1 loads the keycode latch.
// - output channel (out_valid/out_stall) returns exactly one result word per input word,
//   in order: select pulses, completed byte with target device, keyboard reply.
// - cfg_we/cfg_wdata write sd_init_clocks; write only while the block is idle.
// - each result is registered: in the output register, or in the skid register on a stall.
// - throughput: one word per cycle when not stalled; all decode sits between the input
//   handshake and the output register, with the sample state updated in the same cycle.
// - when out_stall holds the output word, one more input word is taken into a skid
//   register; in_stall rises once that skid register is occupied and falls the cycle
//   after the output side drains.
// - reset clears all sample state, the keycode latch and both buffer entries, and
//   sets sd_init_clocks to 74; the block accepts words right after reset.
module spi_port_demux_with_keyboard_responder
    import spdk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       action,
    input  logic [7:0] port,
    input  logic [7:0] keycode,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       sd_select_pulse,
    output logic       rtc_select_pulse,
    output logic       rtc_deselect_pulse,
    output logic       byte_done,
    output logic [1:0] target_device,
    output logic [7:0] received_byte,
    output logic       reply_valid,
    output logic [7:0] reply_byte,
    output logic       kbd_irq_clear
);

    logic accept;
    logic full;
    res_t res;
    res_t out_data;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    spdk_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .action    (action),
        .port      (port),
        .keycode   (keycode),
        .res       (res)
    );

    spdk_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign sd_select_pulse    = out_data.sd_select_pulse;
    assign rtc_select_pulse   = out_data.rtc_select_pulse;
    assign rtc_deselect_pulse = out_data.rtc_deselect_pulse;
    assign byte_done          = out_data.byte_done;
    assign target_device      = out_data.target_device;
    assign received_byte      = out_data.received_byte;
    assign reply_valid        = out_data.reply_valid;
    assign reply_byte         = out_data.reply_byte;
    assign kbd_irq_clear      = out_data.kbd_irq_clear;

endmodule

// File: tb/tb_spi_port_demux_with_keyboard_responder.sv
// self-checking testbench for the spi port demux with keyboard responder
// depends on spdk_pkg and the spi_port_demux_with_keyboard_responder top level
module tb_spi_port_demux_with_keyboard_responder;
    import spdk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 4;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_KEY_LOAD = 1'b1;

    // active-low selects in port order {rtc_n, kbd_n, sd_n}
    localparam logic [2:0] SEL_NONE = 3'b111;
    localparam logic [2:0] SEL_SD = 3'b110;
    localparam logic [2:0] SEL_KBD = 3'b101;
    localparam logic [2:0] SEL_RTC = 3'b011;

    localparam logic [7:0] NULL_BYTE = 8'h00;

    typedef struct packed {
        logic       action;
        logic [7:0] port;
        logic [7:0] keycode;
    } spi_sample_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       action = 1'b0;
    logic [7:0] port = 8'hff;
    logic [7:0] keycode = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       sd_select_pulse;
    logic       rtc_select_pulse;
    logic       rtc_deselect_pulse;
    logic       byte_done;
    logic [1:0] target_device;
    logic [7:0] received_byte;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       kbd_irq_clear;

    spi_sample_t pending_samples[$];
    res_t        expected_results[$];

    int idle_pct = 0;
    int stall_pct = 0;
    logic word_taken = 1'b0;
    int words_queued = 0;
    int words_accepted = 0;
    int results_checked = 0;
    int bytes_seen = 0;
    int kbd_replies = 0;
    int keycode_reads = 0;
    int sd_pulses = 0;
    int mismatches = 0;
    int stuck_cycles = 0;
    logic [7:0] mid_holdoff;

    // predictor state
    logic [7:0] sd_holdoff_clocks = SD_INIT_CLOCKS_RST;
    logic       last_sd_sel = 1'b0;
    logic       last_kbd_sel = 1'b0;
    logic       last_rtc_sel = 1'b0;
    logic       last_sclk = 1'b0;
    logic [7:0] rx_shift = 8'h00;
    logic [7:0] rx_bits = 8'h00;
    logic       sd_card_ready = 1'b0;
    logic [7:0] holdoff_count = 8'h00;
    logic [7:0] kbd_cmd_pending = NULL_BYTE;
    logic [7:0] keycode_latch = 8'h00;

    spi_port_demux_with_keyboard_responder dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .port              (port),
        .keycode           (keycode),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .sd_select_pulse   (sd_select_pulse),
        .rtc_select_pulse  (rtc_select_pulse),
        .rtc_deselect_pulse(rtc_deselect_pulse),
        .byte_done         (byte_done),
        .target_device     (target_device),
        .received_byte     (received_byte),
        .reply_valid       (reply_valid),
        .reply_byte        (reply_byte),
        .kbd_irq_clear     (kbd_irq_clear)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic res_t predict_word(logic act, logic [7:0] p, logic [7:0] kc);
        res_t r;
        logic sclk, sd, kb, rtc, mosi;
        r = '0;
        if (act == ACT_KEY_LOAD)
        begin
            keycode_latch = kc;
            return r;
        end
        sclk = p[0];
        sd = ~p[1];
        kb = ~p[2];
        rtc = ~p[3];
        mosi = p[7];

        // only the first select edge that applies is acted on
        if (!last_sd_sel && sd)
        begin
            rx_bits = 8'h00;
            r.sd_select_pulse = 1'b1;
        end
        else if (!last_kbd_sel && kb)
            rx_bits = 8'h00;
        else if (!last_rtc_sel && rtc)
        begin
            rx_bits = 8'h00;
            r.rtc_select_pulse = 1'b1;
        end
        else if (last_rtc_sel && !rtc)
            r.rtc_deselect_pulse = 1'b1;
        last_sd_sel = sd;
        last_kbd_sel = kb;
        last_rtc_sel = rtc;

        // clock only tracked while something is selected
        if (!(sd || kb || rtc) || sclk == last_sclk)
            return r;
        last_sclk = sclk;
        if (!sclk)
            return r;

        rx_shift = {rx_shift[6:0], mosi};
        rx_bits = rx_bits + 8'd1;

        if (sd && !sd_card_ready)
        begin
            holdoff_count = holdoff_count + 8'd1;
            if (holdoff_count >= sd_holdoff_clocks)
            begin
                sd_card_ready = 1'b1;
                r.sd_select_pulse = 1'b1;
            end
            return r;
        end

        // bit count wraps, so a byte only lands on exactly eight
        if (rx_bits != BITS_PER_BYTE)
            return r;
        rx_bits = 8'h00;
        r.byte_done = 1'b1;
        r.received_byte = rx_shift;
        if (sd)
            r.target_device = DEV_SD;
        else if (kb)
        begin
            r.target_device = DEV_KBD;
            r.reply_valid = 1'b1;
            if (rx_shift != NULL_BYTE && kbd_cmd_pending == NULL_BYTE)
            begin
                r.reply_byte = KBD_NONE;
                case (rx_shift)
                    KBD_CMD_RESTART, KBD_CMD_ENABLE, KBD_CMD_DISABLE, KBD_CMD_RATE,
                    KBD_CMD_INDICATORS:
                    begin
                        kbd_cmd_pending = rx_shift;
                        r.reply_byte = KBD_ACK;
                    end
                    KBD_CMD_STAT1, KBD_CMD_STAT2:
                        r.reply_byte = KBD_ID_OK;
                    default:
                        r.reply_byte = KBD_NONE;
                endcase
            end
            else
            begin
                if (kbd_cmd_pending == KBD_CMD_RATE)
                    r.reply_byte = KBD_ACK;
                else
                begin
                    r.reply_byte = keycode_latch;
                    keycode_latch = 8'h00;
                    r.kbd_irq_clear = 1'b1;
                end
                kbd_cmd_pending = NULL_BYTE;
            end
        end
        else
            r.target_device = DEV_RTC;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // monitor: predicts on accepted words, checks accepted results
    always @(posedge clk)
    begin
        res_t want;
        logic took_in, took_out;
        if (rst_n)
        begin
            took_in = in_valid && !in_stall;
            took_out = out_valid && !out_stall;
            word_taken <= took_in;
            if (cfg_we)
                sd_holdoff_clocks = cfg_wdata;

            if (took_out)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word arrived with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.byte_done) bytes_seen++;
                    if (want.reply_valid) kbd_replies++;
                    if (want.kbd_irq_clear) keycode_reads++;
                    if (want.sd_select_pulse) sd_pulses++;
                    check_field("sd_select_pulse", 8'(want.sd_select_pulse),
                                8'(sd_select_pulse));
                    check_field("rtc_select_pulse", 8'(want.rtc_select_pulse),
                                8'(rtc_select_pulse));
                    check_field("rtc_deselect_pulse", 8'(want.rtc_deselect_pulse),
                                8'(rtc_deselect_pulse));
                    check_field("byte_done", 8'(want.byte_done), 8'(byte_done));
                    check_field("target_device", 8'(want.target_device),
                                8'(target_device));
                    check_field("received_byte", want.received_byte, received_byte);
                    check_field("reply_valid", 8'(want.reply_valid), 8'(reply_valid));
                    check_field("reply_byte", want.reply_byte, reply_byte);
                    check_field("kbd_irq_clear", 8'(want.kbd_irq_clear),
                                8'(kbd_irq_clear));
                end
            end

            if (took_in)
            begin
                expected_results.push_back(predict_word(action, port, keycode));
                words_accepted++;
            end

            if (took_in || took_out)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // driver: new words and stall decisions at the falling edge
    always @(negedge clk)
    begin
        spi_sample_t nxt;
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
            if (!in_valid || word_taken)
            begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = pending_samples.pop_front();
                    in_valid <= 1'b1;
                    action <= nxt.action;
                    port <= nxt.port;
                    keycode <= nxt.keycode;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] spi_port(logic sclk, logic [2:0] sel_n, logic mosi);
        logic [2:0] spare;
        spare = 3'($urandom_range(7));
        return {mosi, spare, sel_n, sclk};
    endfunction

    task automatic queue_sample(logic [7:0] p);
        spi_sample_t s;
        s.action = ACT_SAMPLE;
        s.port = p;
        s.keycode = 8'($urandom_range(255));
        pending_samples.push_back(s);
        words_queued++;
    endtask

    task automatic queue_key_load(logic [7:0] kc, logic [7:0] p);
        spi_sample_t s;
        s.action = ACT_KEY_LOAD;
        s.port = p;
        s.keycode = kc;
        pending_samples.push_back(s);
        words_queued++;
    endtask

    function automatic logic [7:0] pick_kbd_byte();
        case ($urandom_range(9))
            0: return KBD_CMD_RESTART;
            1: return KBD_CMD_ENABLE;
            2: return KBD_CMD_DISABLE;
            3: return KBD_CMD_RATE;
            4: return KBD_CMD_INDICATORS;
            5: return KBD_CMD_STAT1;
            6: return KBD_CMD_STAT2;
            7: return NULL_BYTE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // select, clock out whole bytes msb first, deselect
    task automatic queue_frame(logic [2:0] sel_n, int nbytes);
        logic [7:0] b;
        queue_sample(spi_port(1'b0, sel_n, 1'($urandom_range(1))));
        for (int n = 0; n < nbytes; n++)
        begin
            b = (sel_n == SEL_KBD) ? pick_kbd_byte() : 8'($urandom_range(255));
            for (int i = 7; i >= 0; i--)
            begin
                queue_sample(spi_port(1'b0, sel_n, 1'($urandom_range(1))));
                queue_sample(spi_port(1'b1, sel_n, b[i]));
            end
        end
        queue_sample(spi_port(1'($urandom_range(1)), SEL_NONE, 1'($urandom_range(1))));
    endtask

    task automatic queue_random(int count);
        int target, pick, n;
        logic [2:0] sel_n;
        target = words_queued + count;
        while (words_queued < target)
        begin
            pick = int'($urandom_range(99));
            if (pick < 50)
            begin
                pick = int'($urandom_range(99));
                if (pick < 45)
                begin
                    if ($urandom_range(9) < 3)
                        queue_key_load(8'($urandom_range(255)), 8'($urandom_range(255)));
                    queue_frame(SEL_KBD, int'($urandom_range(1, 3)));
                end
                else if (pick < 75)
                    queue_frame(SEL_SD, int'($urandom_range(1, 3)));
                else
                    queue_frame(SEL_RTC, int'($urandom_range(1, 3)));
            end
            else if (pick < 65)
                queue_key_load(8'($urandom_range(255)), 8'($urandom_range(255)));
            else if (pick < 85)
            begin
                // broken frame: any select mix, partial byte, maybe left selected
                sel_n = 3'($urandom_range(7));
                n = int'($urandom_range(1, 12));
                for (int i = 0; i < n; i++)
                    queue_sample(spi_port(i[0], sel_n, 1'($urandom_range(1))));
                if ($urandom_range(1) != 0)
                    queue_sample(spi_port(1'($urandom_range(1)), SEL_NONE,
                                          1'($urandom_range(1))));
            end
            else
            begin
                n = int'($urandom_range(1, 4));
                for (int i = 0; i < n; i++)
                    queue_sample(8'($urandom_range(255)));
            end
        end
    endtask

    // sender holds off until every word is in and every result is back
    task automatic settle();
        while (words_accepted != words_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_sd_holdoff(logic [7:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: latch extremes, port ignored on loads, edge priority
        queue_key_load(8'hff, 8'h00);
        queue_key_load(8'h00, 8'hff);
        queue_sample(8'hff);
        queue_sample(8'h76);
        queue_sample(8'h87);
        queue_sample(8'h0e);
        queue_sample(8'h00);
        queue_sample(8'h81);
        queue_sample(8'h0f);
        queue_sample(8'h7b);
        queue_sample(8'h7a);
        queue_sample(8'hfb);
        queue_sample(8'h73);
        queue_sample(8'h75);
        queue_key_load(8'h5a, 8'h00);
        queue_sample(8'h0f);
        settle();

        // longest hold-off, one long sd frame so the bit count wraps
        write_sd_holdoff(8'd255);
        idle_pct = 0;
        stall_pct = 0;
        queue_frame(SEL_SD, 34);
        queue_random(160);
        settle();

        write_sd_holdoff(8'd1);
        idle_pct = 58;
        stall_pct = 0;
        queue_random(180);
        settle();

        mid_holdoff = 8'($urandom_range(2, 254));
        write_sd_holdoff(mid_holdoff);
        idle_pct = 0;
        stall_pct = 58;
        queue_random(180);
        settle();

        write_sd_holdoff(SD_INIT_CLOCKS_RST);
        idle_pct = 11;
        stall_pct = 11;
        queue_random(180);
        settle();

        $display("covered %0d words in five phases, sd hold-off 74, 255, 1, %0d and 74",
                 words_accepted, mid_holdoff);
        $display("checked %0d results: %0d bytes, %0d keyboard replies, %0d keycode reads,",
                 results_checked, bytes_seen, kbd_replies, keycode_reads);
        $display("  and %0d sd pulses", sd_pulses);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
